[design/tlca_pkg.sv]
// Shared widths, limits, opcodes and defaults of the tree ancestor block.
package tlca_pkg;

    localparam int NODE_W = 10;
    localparam int LVL_W  = 10;
    localparam int DIST_W = 11;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int LOG_LEVELS_DEF = 10;

    localparam logic [LVL_W-1:0]  LEVEL_MAX = 10'd1023;
    localparam logic [DIST_W-1:0] DIST_MAX  = 11'd2046;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage

[design/tree_lca_binary_lifting.sv]
// Top level of the lowest-common-ancestor block: binary-lifting tables and their sequencer.
//
// Usage. Requests arrive on the s_axis channel: tuser carries the opcode (insert or
// query) and tdata carries node_a in bits 9:0 and node_b in bits 19:10. An insert
// places node_a under parent node_b (parent 0 makes it a root); parents must be
// inserted before their children. A query returns the lowest common ancestor of
// the two nodes, the number of edges between them, the parent of node_a and the
// depth of the ancestor. Every request yields exactly one response on m_axis.
// The block works on one request at a time, and a query is paced by the single read
// port of the ancestor memory: lifting visits every level once and makes one more
// ancestor read per set bit of the depth difference, and the common climb, when it
// is needed, makes two ancestor reads per level. An insert builds its rows in level order.
// The next request is taken from the cycle after the response register is loaded.
// A finished response sits in an output register, so the next request is taken
// while it waits for m_axis_tready; only a second response waiting behind a stalled
// one holds the block. Reset clears the sequencer and the output valid flag. The
// tables are not cleared: an entry is meaningful only once its node has been
// inserted, and node 0 and nodes beyond MAX_NODES always read as zero.
module tree_lca_binary_lifting #(
    parameter int MAX_NODES  = tlca_pkg::MAX_NODES_DEF,
    parameter int LOG_LEVELS = tlca_pkg::LOG_LEVELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: node_a [9:0], node_b [19:10], zero padding [23:20]
    input  logic [tlca_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode [0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: ancestor_node [9:0], path_distance [20:10], parent_of_first [30:21],
    //        node_level [40:31], zero padding [47:41]
    output logic [tlca_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import tlca_pkg::*;

    // Node address width and lifting-level index width.
    localparam int AW     = $clog2(MAX_NODES);
    localparam int LW     = $clog2(LOG_LEVELS);
    localparam int AN_DEP = MAX_NODES << LW;
    localparam logic [LW-1:0] J_TOP = LW'(LOG_LEVELS - 1);
    localparam int PAD_W  = OUT_TDATA_W - (NODE_W + DIST_W + NODE_W + LVL_W);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_I_START = 16'h0002,
        S_I_LVL   = 16'h0004,
        S_I_CHAIN = 16'h0008,
        S_Q_LA    = 16'h0010,
        S_Q_LB    = 16'h0020,
        S_Q_PA    = 16'h0040,
        S_Q_SWAP  = 16'h0080,
        S_Q_LIFT  = 16'h0100,
        S_Q_LIFTW = 16'h0200,
        S_Q_EQ    = 16'h0400,
        S_Q_UPB   = 16'h0800,
        S_Q_UPC   = 16'h1000,
        S_Q_PARW  = 16'h2000,
        S_Q_DIST  = 16'h4000,
        S_DONE    = 16'h8000
    } t_state;

    // A node has stored rows only if it is not the sentinel and lies inside the table.
    function automatic logic node_live(input logic [NODE_W-1:0] n);
        return (n != '0) && (32'(n) < MAX_NODES);
    endfunction

    function automatic logic [AW-1:0] node_addr(input logic [NODE_W-1:0] n);
        logic [NODE_W+15:0] w;
        w = {16'b0, n};
        return w[AW-1:0];
    endfunction

    t_state r_state, n_state;

    logic              r_op, n_op;
    logic [NODE_W-1:0] r_a, n_a;
    logic [NODE_W-1:0] r_b, n_b;
    logic              r_a_ok, n_a_ok;
    logic [NODE_W-1:0] r_p, n_p;
    logic [LVL_W-1:0]  r_d, n_d;
    logic [NODE_W-1:0] r_x, n_x;
    logic [NODE_W-1:0] r_y, n_y;
    logic [LW-1:0]     r_j, n_j;
    logic [LVL_W-1:0]  r_k, n_k;
    logic [LVL_W-1:0]  r_la, n_la;
    logic [LVL_W-1:0]  r_lb, n_lb;
    logic [NODE_W-1:0] r_pa, n_pa;
    logic [NODE_W-1:0] r_ua, n_ua;
    logic [NODE_W-1:0] r_c, n_c;

    logic [NODE_W-1:0] r_res_anc, n_res_anc;
    logic [DIST_W-1:0] r_res_dist, n_res_dist;
    logic [NODE_W-1:0] r_res_par, n_res_par;
    logic [LVL_W-1:0]  r_res_lvl, n_res_lvl;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // Memory ports.
    logic              lv_we;
    logic [AW-1:0]     lv_waddr;
    logic [LVL_W-1:0]  lv_wdata;
    logic [AW-1:0]     lv_raddr;
    logic              lv_zero;
    logic [LVL_W-1:0]  lv_q;
    logic              an_we;
    logic [AW+LW-1:0]  an_waddr;
    logic [NODE_W-1:0] an_wdata;
    logic [AW+LW-1:0]  an_raddr;
    logic              an_zero;
    logic [NODE_W-1:0] an_q;

    // Read-side qualifiers, registered alongside the memory read.
    logic              r_lv_zero;
    logic              r_an_zero;
    logic              r_an_fwd;
    logic [NODE_W-1:0] r_an_fwd_d;
    logic [LVL_W-1:0]  lv_eff;
    logic [NODE_W-1:0] an_eff;

    // Combinational helpers.
    logic [NODE_W-1:0] in_a, in_b, par_in;
    logic [LVL_W-1:0]  d_calc;
    logic [LVL_W-1:0]  k_sh;
    logic [NODE_W-1:0] nx, ny;
    logic [DIST_W+1:0] sum_ab, two_c, diff;

    tlca_ram #(
        .WIDTH (LVL_W),
        .DEPTH (MAX_NODES)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lv_we),
        .i_waddr (lv_waddr),
        .i_wdata (lv_wdata),
        .i_raddr (lv_raddr),
        .o_rdata (lv_q)
    );

    tlca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (AN_DEP)
    ) u_ancestor_ram (
        .i_clk   (i_clk),
        .i_we    (an_we),
        .i_waddr (an_waddr),
        .i_wdata (an_wdata),
        .i_raddr (an_raddr),
        .o_rdata (an_q)
    );

    // The sentinel and out-of-range nodes read as zero. During an insert the
    // row just written may be read back in the same cycle, so that value is
    // forwarded past the memory.
    assign lv_eff = r_lv_zero ? '0 : lv_q;
    assign an_eff = r_an_zero ? '0 : (r_an_fwd ? r_an_fwd_d : an_q);

    assign in_a   = s_axis_tdata[NODE_W-1:0];
    assign in_b   = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign par_in = (32'(r_b) < MAX_NODES) ? r_b : '0;

    // Depth of a new node: one below its parent, held at the top level.
    assign d_calc = (r_p == '0)        ? '0 :
                    (lv_eff == LEVEL_MAX) ? LEVEL_MAX : lv_eff + 1'b1;

    assign k_sh = r_k >> r_j;

    // One step of the common climb: move both nodes up while their ancestors differ.
    assign nx = (r_ua != an_eff) ? r_ua   : r_x;
    assign ny = (r_ua != an_eff) ? an_eff : r_y;

    // Path length from the three depths, clamped into range.
    assign sum_ab = (DIST_W+2)'(r_la) + (DIST_W+2)'(r_lb);
    assign two_c  = (DIST_W+2)'(lv_eff) << 1;
    assign diff   = sum_ab - two_c;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_a        = r_a;
        n_b        = r_b;
        n_a_ok     = r_a_ok;
        n_p        = r_p;
        n_d        = r_d;
        n_x        = r_x;
        n_y        = r_y;
        n_j        = r_j;
        n_k        = r_k;
        n_la       = r_la;
        n_lb       = r_lb;
        n_pa       = r_pa;
        n_ua       = r_ua;
        n_c        = r_c;
        n_res_anc  = r_res_anc;
        n_res_dist = r_res_dist;
        n_res_par  = r_res_par;
        n_res_lvl  = r_res_lvl;
        n_out_data = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;

        lv_we    = 1'b0;
        lv_waddr = node_addr(r_a);
        lv_wdata = d_calc;
        lv_raddr = '0;
        lv_zero  = 1'b1;
        an_we    = 1'b0;
        an_waddr = {node_addr(r_a), r_j};
        an_wdata = an_eff;
        an_raddr = '0;
        an_zero  = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = s_axis_tuser;
                    n_a     = in_a;
                    n_b     = in_b;
                    n_state = (s_axis_tuser == OP_INSERT) ? S_I_START : S_Q_LA;
                end
            end

            // Insert: store the parent as the first row and fetch its depth.
            S_I_START: begin
                n_a_ok   = node_live(r_a);
                n_p      = par_in;
                n_x      = par_in;
                n_j      = LW'(1);
                an_we    = node_live(r_a);
                an_waddr = {node_addr(r_a), LW'(0)};
                an_wdata = par_in;
                lv_raddr = node_addr(par_in);
                lv_zero  = !node_live(par_in);
                n_state  = S_I_LVL;
            end

            S_I_LVL: begin
                n_d      = d_calc;
                lv_we    = r_a_ok;
                an_raddr = {node_addr(r_x), LW'(0)};
                an_zero  = !node_live(r_x);
                n_state  = S_I_CHAIN;
            end

            // Row j of the new node is row j-1 of its ancestor 2^(j-1) levels up.
            S_I_CHAIN: begin
                an_we    = r_a_ok;
                an_waddr = {node_addr(r_a), r_j};
                an_wdata = an_eff;
                n_x      = an_eff;
                if (r_j == J_TOP) begin
                    n_res_anc  = '0;
                    n_res_dist = '0;
                    n_res_par  = r_a_ok ? r_p : '0;
                    n_res_lvl  = r_a_ok ? r_d : '0;
                    n_state    = S_DONE;
                end else begin
                    an_raddr = {node_addr(an_eff), r_j};
                    an_zero  = !node_live(an_eff);
                    n_j      = r_j + 1'b1;
                end
            end

            S_Q_LA: begin
                lv_raddr = node_addr(r_a);
                lv_zero  = !node_live(r_a);
                n_state  = S_Q_LB;
            end

            S_Q_LB: begin
                n_la     = lv_eff;
                lv_raddr = node_addr(r_b);
                lv_zero  = !node_live(r_b);
                n_state  = S_Q_PA;
            end

            S_Q_PA: begin
                n_lb     = lv_eff;
                an_raddr = {node_addr(r_a), LW'(0)};
                an_zero  = !node_live(r_a);
                n_state  = S_Q_SWAP;
            end

            // The deeper node goes to x and is lifted by the depth difference.
            S_Q_SWAP: begin
                n_pa = an_eff;
                if (r_la < r_lb) begin
                    n_x = r_b;
                    n_y = r_a;
                    n_k = r_lb - r_la;
                end else begin
                    n_x = r_a;
                    n_y = r_b;
                    n_k = r_la - r_lb;
                end
                n_j     = J_TOP;
                n_state = S_Q_LIFT;
            end

            S_Q_LIFT: begin
                if (k_sh[0]) begin
                    an_raddr = {node_addr(r_x), r_j};
                    an_zero  = !node_live(r_x);
                    n_state  = S_Q_LIFTW;
                end else if (r_j == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_j = r_j - 1'b1;
                end
            end

            S_Q_LIFTW: begin
                n_x = an_eff;
                if (r_j == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_j     = r_j - 1'b1;
                    n_state = S_Q_LIFT;
                end
            end

            S_Q_EQ: begin
                if (r_x == r_y) begin
                    n_c      = r_x;
                    lv_raddr = node_addr(r_x);
                    lv_zero  = !node_live(r_x);
                    n_state  = S_Q_DIST;
                end else begin
                    n_j      = J_TOP;
                    an_raddr = {node_addr(r_x), J_TOP};
                    an_zero  = !node_live(r_x);
                    n_state  = S_Q_UPB;
                end
            end

            S_Q_UPB: begin
                n_ua     = an_eff;
                an_raddr = {node_addr(r_y), r_j};
                an_zero  = !node_live(r_y);
                n_state  = S_Q_UPC;
            end

            S_Q_UPC: begin
                n_x = nx;
                n_y = ny;
                if (r_j == '0) begin
                    an_raddr = {node_addr(nx), LW'(0)};
                    an_zero  = !node_live(nx);
                    n_state  = S_Q_PARW;
                end else begin
                    an_raddr = {node_addr(nx), r_j - 1'b1};
                    an_zero  = !node_live(nx);
                    n_j      = r_j - 1'b1;
                    n_state  = S_Q_UPB;
                end
            end

            // The parent of the last differing node is the common ancestor.
            S_Q_PARW: begin
                n_c      = an_eff;
                lv_raddr = node_addr(an_eff);
                lv_zero  = !node_live(an_eff);
                n_state  = S_Q_DIST;
            end

            S_Q_DIST: begin
                n_res_anc = r_c;
                n_res_par = r_pa;
                n_res_lvl = lv_eff;
                if (sum_ab < two_c) begin
                    n_res_dist = '0;
                end else if (diff > (DIST_W+2)'(DIST_MAX)) begin
                    n_res_dist = DIST_MAX;
                end else begin
                    n_res_dist = diff[DIST_W-1:0];
                end
                n_state = S_DONE;
            end

            // Hand the response to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{PAD_W{1'b0}}, r_res_lvl, r_res_par, r_res_dist,
                                   r_res_anc};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_a        <= n_a;
        r_b        <= n_b;
        r_a_ok     <= n_a_ok;
        r_p        <= n_p;
        r_d        <= n_d;
        r_x        <= n_x;
        r_y        <= n_y;
        r_j        <= n_j;
        r_k        <= n_k;
        r_la       <= n_la;
        r_lb       <= n_lb;
        r_pa       <= n_pa;
        r_ua       <= n_ua;
        r_c        <= n_c;
        r_res_anc  <= n_res_anc;
        r_res_dist <= n_res_dist;
        r_res_par  <= n_res_par;
        r_res_lvl  <= n_res_lvl;
        r_out_data <= n_out_data;
        r_lv_zero  <= lv_zero;
        r_an_zero  <= an_zero;
        r_an_fwd   <= an_we && (an_waddr == an_raddr);
        r_an_fwd_d <= an_wdata;
    end

endmodule

[design/tlca_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module tlca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tree_lca_binary_lifting_test.sv]
// Self-checking testbench for the binary-lifting lowest-common-ancestor block.
module tree_lca_binary_lifting_test;

    import tlca_pkg::*;

    // The tree model uses the same table sizes as the block's defaults.
    localparam int MAX_NODE_COUNT = MAX_NODES_DEF;
    localparam int LIFT_LEVELS    = LOG_LEVELS_DEF;
    localparam int PAD_W          = OUT_TDATA_W - (2 * NODE_W + DIST_W + LVL_W);

    // The tail covers any response still in flight once the last one has arrived.
    localparam int TAIL_CYCLES     = 4 * LIFT_LEVELS + 20;
    // Cycles with no request or response accepted before the run is abandoned.
    // The slowest legal gap is one query plus a short random stall on each side,
    // so this limit is many times the worst case.
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_REQUESTS = 100;
    localparam int REPORT_LIMIT    = 10;
    // Nodes in the long chain; deep enough that the top lifting level is used.
    localparam int CHAIN_LEN       = 520;

    // One response as it sits in m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [LVL_W-1:0]  level;
        logic [NODE_W-1:0] parent;
        logic [DIST_W-1:0] span;
        logic [NODE_W-1:0] anc;
    } t_answer;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: node_a [9:0], node_b [19:10], zero padding [23:20]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser: opcode [0]
    logic                   s_axis_tuser = OP_INSERT;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: ancestor_node [9:0], path_distance [20:10], parent_of_first [30:21],
    //        node_level [40:31], zero padding [47:41]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Our own copy of the tree: the depth of every node and its lifting rows,
    // where row j holds the ancestor 2^j levels up. Node 0 is never written.
    logic [LVL_W-1:0]  depth_of [MAX_NODE_COUNT];
    logic [NODE_W-1:0] lift_row [MAX_NODE_COUNT][LIFT_LEVELS];

    // Nodes inserted so far, so that stray queries only touch written rows.
    bit                known [MAX_NODE_COUNT];
    logic [NODE_W-1:0] known_nodes [$];

    t_answer     pending_answers [$];
    int          mismatch_count = 0;
    int          requests_sent  = 0;
    int          responses_seen = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 33;
    int          ready_idle_pct = 33;

    tree_lca_binary_lifting i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The sentinel node 0 reads as zero in every row, whatever the tables hold.
    function automatic logic [LVL_W-1:0] depth_at(input logic [NODE_W-1:0] node);
        return (node == '0) ? '0 : depth_of[node];
    endfunction

    function automatic logic [NODE_W-1:0] lift_at(input logic [NODE_W-1:0] node,
                                                  input int row);
        return (node == '0) ? '0 : lift_row[node][row];
    endfunction

    // Classic two-stage climb: first lift the deeper node by the depth
    // difference, then climb both together while their ancestors differ.
    function automatic logic [NODE_W-1:0] common_ancestor(input logic [NODE_W-1:0] a,
                                                          input logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] held, up_a, up_b;
        logic [LVL_W-1:0]  gap;
        if (depth_at(a) < depth_at(b)) begin
            held = a;
            a    = b;
            b    = held;
        end
        gap = depth_at(a) - depth_at(b);
        for (int j = LIFT_LEVELS - 1; j >= 0; j--) begin
            if (gap[j]) begin
                a = lift_at(a, j);
            end
        end
        if (a == b) begin
            return a;
        end
        for (int j = LIFT_LEVELS - 1; j >= 0; j--) begin
            up_a = lift_at(a, j);
            up_b = lift_at(b, j);
            if (up_a != up_b) begin
                a = up_a;
                b = up_b;
            end
        end
        return lift_at(a, 0);
    endfunction

    // Applies one accepted request to the tree copy and returns the response
    // that the block must give for it.
    function automatic t_answer predict_answer(input logic op,
                                               input logic [NODE_W-1:0] a,
                                               input logic [NODE_W-1:0] b);
        t_answer answer;
        logic [NODE_W-1:0] lca;
        int depth, span;
        answer = '0;
        if (op == OP_INSERT) begin
            // Writing the sentinel is silently dropped; its zero rows are reported.
            if (a != '0) begin
                depth = 0;
                if (b != '0) begin
                    depth = int'(depth_at(b)) + 1;
                    if (depth > int'(LEVEL_MAX)) begin
                        depth = int'(LEVEL_MAX);
                    end
                end
                depth_of[a]    = LVL_W'(depth);
                lift_row[a][0] = b;
                // Rows are built in place, so a node made its own parent
                // sees its freshly written lower row.
                for (int j = 1; j < LIFT_LEVELS; j++) begin
                    lift_row[a][j] = lift_at(lift_row[a][j-1], j - 1);
                end
                if (!known[a]) begin
                    known[a] = 1'b1;
                    known_nodes.insert(known_nodes.size(), a);
                end
            end
            answer.parent = lift_at(a, 0);
            answer.level  = depth_at(a);
        end else begin
            lca  = common_ancestor(a, b);
            // A tree broken by re-insertion or a loop can push this out of range.
            span = int'(depth_at(a)) + int'(depth_at(b)) - 2 * int'(depth_at(lca));
            if (span < 0) begin
                span = 0;
            end
            if (span > int'(DIST_MAX)) begin
                span = int'(DIST_MAX);
            end
            answer.anc    = lca;
            answer.span   = DIST_W'(span);
            answer.parent = lift_at(a, 0);
            answer.level  = depth_at(lca);
        end
        return answer;
    endfunction

    // Offers one request at the falling edge, after a random idle spell, and
    // holds it until the rising edge at which it is taken. tvalid is left high
    // so that back-to-back requests never lower and raise it in one step.
    task automatic issue_request(input logic op, input logic [NODE_W-1:0] a,
                                 input logic [NODE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - 2 * NODE_W){1'b0}}, b, a};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_answers.insert(pending_answers.size(), predict_answer(op, a, b));
        requests_sent++;
    endtask

    // Mostly a member of the pool, sometimes the sentinel and sometimes any
    // node inserted so far.
    function automatic logic [NODE_W-1:0] pick_query_node(input logic [NODE_W-1:0] pool [$]);
        if ($urandom_range(15) == 0) begin
            return '0;
        end
        if ($urandom_range(9) == 0) begin
            return known_nodes[$urandom_range(known_nodes.size() - 1)];
        end
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    // Sentinel handling: writing node 0 and asking about node 0 itself.
    task automatic test_sentinel();
        issue_request(OP_INSERT, 10'd0, 10'd0);
        issue_request(OP_QUERY, 10'd0, 10'd0);
    endtask

    // A small hand-built forest using the extreme node numbers, followed by
    // re-insertion and a loop that leaves the depths inconsistent.
    task automatic test_small_tree();
        issue_request(OP_INSERT, 10'd1023, 10'd0);
        issue_request(OP_INSERT, 10'd512, 10'd1023);
        issue_request(OP_INSERT, 10'd1, 10'd512);
        issue_request(OP_INSERT, 10'h155, 10'd512);
        issue_request(OP_INSERT, 10'h2AA, 10'd1);
        // Nodes on different branches, ancestor with descendant, a node with itself.
        issue_request(OP_QUERY, 10'h2AA, 10'h155);
        issue_request(OP_QUERY, 10'd1023, 10'h2AA);
        issue_request(OP_QUERY, 10'h2AA, 10'h2AA);
        // Nodes in different trees meet only at the sentinel.
        issue_request(OP_QUERY, 10'd1, 10'd0);
        issue_request(OP_INSERT, 10'd5, 10'd0);
        issue_request(OP_QUERY, 10'd5, 10'h155);
        // A sentinel write with a real parent must leave the tables alone.
        issue_request(OP_INSERT, 10'd0, 10'd512);
        issue_request(OP_QUERY, 10'd512, 10'd1);
        // Move a node to a deeper parent, then close a loop through the tree.
        issue_request(OP_INSERT, 10'h155, 10'h2AA);
        issue_request(OP_QUERY, 10'h155, 10'd1);
        issue_request(OP_INSERT, 10'd512, 10'h2AA);
        issue_request(OP_QUERY, 10'h2AA, 10'h155);
        issue_request(OP_QUERY, 10'h155, 10'd1023);
        issue_request(OP_QUERY, 10'd512, 10'd5);
    endtask

    // A long chain of shuffled nodes, deep enough to use every lifting level,
    // with neither side idling. Closing the chain into a loop then leaves the
    // depths inconsistent.
    task automatic test_deep_chain();
        int order [MAX_NODE_COUNT - 1];
        int pick, swap, last;
        for (int n = 0; n < MAX_NODE_COUNT - 1; n++) begin
            order[n] = n + 1;
        end
        for (int n = MAX_NODE_COUNT - 2; n > 0; n--) begin
            pick     = $urandom_range(n);
            swap     = order[n];
            order[n] = order[pick];
            order[pick] = swap;
        end
        last           = CHAIN_LEN - 1;
        send_idle_pct  = 0;
        ready_idle_pct = 0;
        issue_request(OP_INSERT, NODE_W'(order[0]), 10'd0);
        for (int n = 1; n <= last; n++) begin
            issue_request(OP_INSERT, NODE_W'(order[n]), NODE_W'(order[n-1]));
        end
        issue_request(OP_QUERY, NODE_W'(order[last]), NODE_W'(order[0]));
        issue_request(OP_QUERY, NODE_W'(order[0]), NODE_W'(order[last]));
        repeat (20) begin
            issue_request(OP_QUERY, NODE_W'(order[$urandom_range(last)]),
                          NODE_W'(order[$urandom_range(last)]));
        end
        issue_request(OP_INSERT, NODE_W'(order[0]), NODE_W'(order[last]));
        issue_request(OP_INSERT, NODE_W'(order[1]), NODE_W'(order[0]));
        issue_request(OP_QUERY, NODE_W'(order[1]), NODE_W'(order[0]));
        issue_request(OP_QUERY, NODE_W'(order[0]), NODE_W'(order[CHAIN_LEN / 2]));
        issue_request(OP_QUERY, NODE_W'(order[last]), NODE_W'(order[1]));
        send_idle_pct  = 33;
        ready_idle_pct = 33;
    endtask

    // Random forests built parent first, each followed by a burst of queries.
    // Now and then a stray query, a sentinel write or a re-insertion is mixed in.
    task automatic test_random_forests();
        logic [NODE_W-1:0] batch [$];
        logic [NODE_W-1:0] node, parent;
        bit taken [MAX_NODE_COUNT];
        int first, size;
        first = requests_sent;
        while (requests_sent - first < RANDOM_REQUESTS) begin
            batch.delete();
            foreach (taken[n]) begin
                taken[n] = 1'b0;
            end
            size = $urandom_range(4, 40);
            while (batch.size() < size) begin
                node = NODE_W'($urandom_range(1, MAX_NODE_COUNT - 1));
                if (!taken[node]) begin
                    taken[node] = 1'b1;
                    // Favour the newest node as parent so that some trees grow deep.
                    if (batch.size() == 0 || $urandom_range(7) == 0) begin
                        parent = '0;
                    end else if ($urandom_range(1) == 1) begin
                        parent = batch[batch.size() - 1];
                    end else begin
                        parent = batch[$urandom_range(batch.size() - 1)];
                    end
                    issue_request(OP_INSERT, node, parent);
                    batch.insert(batch.size(), node);
                    if ($urandom_range(4) == 0) begin
                        issue_request(OP_QUERY, pick_query_node(batch), pick_query_node(batch));
                    end
                    if ($urandom_range(11) == 0) begin
                        if ($urandom_range(1) == 1) begin
                            issue_request(OP_INSERT, '0, pick_query_node(batch));
                        end else begin
                            issue_request(OP_INSERT, pick_query_node(batch),
                                          pick_query_node(batch));
                        end
                    end
                end
            end
            repeat ($urandom_range(size / 2, 2 * size)) begin
                issue_request(OP_QUERY, pick_query_node(batch), pick_query_node(batch));
            end
        end
    endtask

    // The receiver stalls at random; the rate drops to zero during the chain.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= ready_idle_pct);
    end

    // Every accepted response is held against the oldest expectation.
    always @(posedge i_clk) begin : check_responses
        t_answer want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_answer'(m_axis_tdata);
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("response %0d unexpected: anc %0d span %0d parent %0d level %0d",
                             responses_seen, got.anc, got.span, got.parent, got.level);
                end
            end else begin
                want = pending_answers.pop_front();
                if (got.anc !== want.anc || got.span !== want.span ||
                    got.parent !== want.parent || got.level !== want.level ||
                    got.pad !== want.pad) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("response %0d expected anc %0d span %0d parent %0d level %0d pad %0h",
                                 responses_seen, want.anc, want.span, want.parent, want.level,
                                 want.pad);
                        $display("response %0d actual   anc %0d span %0d parent %0d level %0d pad %0h",
                                 responses_seen, got.anc, got.span, got.parent, got.level,
                                 got.pad);
                    end
                end
            end
            responses_seen++;
        end
    end

    // Abandons the run if the block stops taking requests or giving responses.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tree_lca_binary_lifting_test failed");
                $finish;
            end
        end
    end

    initial begin
        // The tables are undefined in the block, but only written entries are
        // ever read, so starting the copy at zero is harmless.
        foreach (depth_of[n]) begin
            depth_of[n] = '0;
            known[n]    = 1'b0;
            for (int j = 0; j < LIFT_LEVELS; j++) begin
                lift_row[n][j] = '0;
            end
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sentinel();
        test_small_tree();
        test_deep_chain();
        test_random_forests();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("tree_lca_binary_lifting_test passed");
        end else begin
            $display("tree_lca_binary_lifting_test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/tlca_pkg.sv
design/tlca_ram.sv
design/tree_lca_binary_lifting.sv
tb/tree_lca_binary_lifting_test.sv
